// ----- design/ngh_pkg.sv -----
`default_nettype none

package ngh_pkg;

  localparam logic [31:0] ONE_Q31       = 32'h8000_0000;
  localparam logic [31:0] OPEN_STEP_Q32 = 32'd1288490189;
  localparam logic [31:0] RECIP_THREE   = 32'hAAAA_AAAB;
  localparam logic [31:0] RECIP_FIVE    = 32'hCCCC_CCCD;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_GATE_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_MS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HPF_B0      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HPF_A1      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HPF_A2      = 3'd5;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ENV_FAST,
    OP_ENV_SLOW,
    OP_FILT_B0,
    OP_FILT_Y,
    OP_FILT_A1,
    OP_FILT_A2,
    OP_FILT_END,
    OP_GATE_R35,
    OP_GATE_RD,
    OP_GATE_T,
    OP_GATE_TS,
    OP_GATE_DEN,
    OP_DIV_INIT,
    OP_DIV,
    OP_SQR,
    OP_X2,
    OP_CUBE,
    OP_X3,
    OP_SIXTH,
    OP_ALPHA,
    OP_FOLLOW,
    OP_FOLLOW_END,
    OP_OPEN,
    OP_OPEN_END,
    OP_UNITY,
    OP_OUT,
    OP_OUT_END
  } op_e;

  typedef struct packed {
    op_e  op;
    logic load;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic gate_en;
    logic opening;
  } sts_t;

endpackage

`default_nettype wire

// ----- design/ngh_ctrl.sv -----
`default_nettype none

module ngh_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire ngh_pkg::sts_t sts_i,
  output ngh_pkg::cmd_t      cmd_o
);

  typedef enum logic [27:0] {
    S_IDLE       = 28'h0000001,
    S_ENV_FAST   = 28'h0000002,
    S_ENV_SLOW   = 28'h0000004,
    S_FILT_B0    = 28'h0000008,
    S_FILT_Y     = 28'h0000010,
    S_FILT_A1    = 28'h0000020,
    S_FILT_A2    = 28'h0000040,
    S_FILT_END   = 28'h0000080,
    S_GATE_R35   = 28'h0000100,
    S_GATE_RD    = 28'h0000200,
    S_GATE_T     = 28'h0000400,
    S_GATE_TS    = 28'h0000800,
    S_GATE_DEN   = 28'h0001000,
    S_DIV_INIT   = 28'h0002000,
    S_DIV        = 28'h0004000,
    S_SQR        = 28'h0008000,
    S_X2         = 28'h0010000,
    S_CUBE       = 28'h0020000,
    S_X3         = 28'h0040000,
    S_SIXTH      = 28'h0080000,
    S_ALPHA      = 28'h0100000,
    S_FOLLOW     = 28'h0200000,
    S_FOLLOW_END = 28'h0400000,
    S_OPEN       = 28'h0800000,
    S_OPEN_END   = 28'h1000000,
    S_UNITY      = 28'h2000000,
    S_OUT        = 28'h4000000,
    S_OUT_END    = 28'h8000000
  } state_e;

  state_e state_q, state_d;
  logic [4:0] div_cnt_q, div_cnt_d;
  logic out_valid_q, out_valid_d;
  logic out_free;
  ngh_pkg::op_e op;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    div_cnt_d = div_cnt_q;
    op        = ngh_pkg::OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_ENV_FAST;
        end
      end
      S_ENV_FAST: begin
        op = ngh_pkg::OP_ENV_FAST;
        state_d = S_ENV_SLOW;
      end
      S_ENV_SLOW: begin
        op = ngh_pkg::OP_ENV_SLOW;
        state_d = S_FILT_B0;
      end
      S_FILT_B0: begin
        op = ngh_pkg::OP_FILT_B0;
        state_d = S_FILT_Y;
      end
      S_FILT_Y: begin
        op = ngh_pkg::OP_FILT_Y;
        state_d = S_FILT_A1;
      end
      S_FILT_A1: begin
        op = ngh_pkg::OP_FILT_A1;
        state_d = S_FILT_A2;
      end
      S_FILT_A2: begin
        op = ngh_pkg::OP_FILT_A2;
        state_d = S_FILT_END;
      end
      S_FILT_END: begin
        op = ngh_pkg::OP_FILT_END;
        state_d = sts_i.gate_en ? S_GATE_R35 : S_UNITY;
      end
      S_GATE_R35: begin
        op = ngh_pkg::OP_GATE_R35;
        state_d = S_GATE_RD;
      end
      S_GATE_RD: begin
        op = ngh_pkg::OP_GATE_RD;
        state_d = S_GATE_T;
      end
      S_GATE_T: begin
        op = ngh_pkg::OP_GATE_T;
        state_d = S_GATE_TS;
      end
      S_GATE_TS: begin
        op = ngh_pkg::OP_GATE_TS;
        state_d = sts_i.opening ? S_OPEN : S_GATE_DEN;
      end
      S_GATE_DEN: begin
        op = ngh_pkg::OP_GATE_DEN;
        state_d = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        op = ngh_pkg::OP_DIV_INIT;
        div_cnt_d = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        op = ngh_pkg::OP_DIV;
        div_cnt_d = div_cnt_q + 5'd1;
        if (&div_cnt_q) begin
          state_d = S_SQR;
        end
      end
      S_SQR: begin
        op = ngh_pkg::OP_SQR;
        state_d = S_X2;
      end
      S_X2: begin
        op = ngh_pkg::OP_X2;
        state_d = S_CUBE;
      end
      S_CUBE: begin
        op = ngh_pkg::OP_CUBE;
        state_d = S_X3;
      end
      S_X3: begin
        op = ngh_pkg::OP_X3;
        state_d = S_SIXTH;
      end
      S_SIXTH: begin
        op = ngh_pkg::OP_SIXTH;
        state_d = S_ALPHA;
      end
      S_ALPHA: begin
        op = ngh_pkg::OP_ALPHA;
        state_d = S_FOLLOW;
      end
      S_FOLLOW: begin
        op = ngh_pkg::OP_FOLLOW;
        state_d = S_FOLLOW_END;
      end
      S_FOLLOW_END: begin
        op = ngh_pkg::OP_FOLLOW_END;
        state_d = S_OUT;
      end
      S_OPEN: begin
        op = ngh_pkg::OP_OPEN;
        state_d = S_OPEN_END;
      end
      S_OPEN_END: begin
        op = ngh_pkg::OP_OPEN_END;
        state_d = S_OUT;
      end
      S_UNITY: begin
        op = ngh_pkg::OP_UNITY;
        state_d = S_OUT;
      end
      S_OUT: begin
        op = ngh_pkg::OP_OUT;
        state_d = S_OUT_END;
      end
      S_OUT_END: begin
        op = ngh_pkg::OP_OUT_END;
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o.op       = op;
    cmd_o.load     = in_valid_i && in_ready_o;
    cmd_o.out_load = (state_q == S_OUT_END) && out_free;
    out_valid_d    = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/ngh_dp.sv -----
`default_nettype none

module ngh_dp #(
  parameter int unsigned SAMPLE_RATE = 48000
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire ngh_pkg::cmd_t                   cmd_i,
  output ngh_pkg::sts_t                        sts_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [ngh_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [ngh_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic signed [23:0]              sample_in_i,
  output logic signed [23:0]                   sample_out_o,
  output logic [31:0]                          gain_now_o
);

  localparam longint unsigned NUM = 64'd1000 << 48;

  localparam longint unsigned XF5  = NUM / (64'd327680 * SAMPLE_RATE);
  localparam longint unsigned X2F5 = (XF5 * XF5) >> 32;
  localparam longint unsigned X3F5 = (X2F5 * XF5) >> 32;
  localparam longint unsigned AF5  = XF5 - X2F5 / 2 + X3F5 / 6;

  localparam longint unsigned XF60  = NUM / (64'd3932160 * SAMPLE_RATE);
  localparam longint unsigned X2F60 = (XF60 * XF60) >> 32;
  localparam longint unsigned X3F60 = (X2F60 * XF60) >> 32;
  localparam longint unsigned AF60  = XF60 - X2F60 / 2 + X3F60 / 6;

  localparam longint unsigned XF250  = NUM / (64'd16384000 * SAMPLE_RATE);
  localparam longint unsigned X2F250 = (XF250 * XF250) >> 32;
  localparam longint unsigned X3F250 = (X2F250 * XF250) >> 32;
  localparam longint unsigned AF250  = XF250 - X2F250 / 2 + X3F250 / 6;

  localparam logic [31:0] ALPHA_5   = AF5[31:0];
  localparam logic [31:0] ALPHA_60  = AF60[31:0];
  localparam logic [31:0] ALPHA_250 = AF250[31:0];

  localparam logic [27:0] MIN_RELEASE = 28'd327680;
  localparam logic [45:0] DIV_REM_INIT = 46'd65536000;

  function automatic logic signed [39:0] sat40(input logic signed [43:0] v);
    logic ok;
    ok = (&v[43:39]) || !(|v[43:39]);
    return ok ? v[39:0] : {v[43], {39{!v[43]}}};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
    logic ok;
    ok = (&v[43:31]) || !(|v[43:31]);
    return ok ? v[31:0] : {v[43], {31{!v[43]}}};
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [65:0] v);
    logic ok;
    ok = (&v[65:23]) || !(|v[65:23]);
    return ok ? v[23:0] : {v[65], {23{!v[65]}}};
  endfunction

  logic        gate_en_q;
  logic [22:0] threshold_q;
  logic [11:0] release_q;
  logic signed [31:0] b0_q, a1_q, a2_q;

  logic [31:0] fast_q, slow_q, gain_q;
  logic signed [39:0] s1_q, s2_q;

  logic signed [23:0] x_q;
  logic signed [65:0] prod_q;
  logic signed [39:0] b0x_q, b1x_q;
  logic signed [31:0] y_q;
  logic [31:0] dens_q;
  logic [27:0] rd_q, t_q;
  logic [45:0] den_q, rem_q;
  logic [31:0] quo_q, x2_q, x3_q, a_q;
  logic signed [23:0] sample_out_q;
  logic [31:0] gain_out_q;

  logic signed [32:0] ma, mb;
  logic mul_en;

  logic [23:0] absx;
  logic [31:0] rect;
  logic rise_f, rise_s;
  logic [31:0] p_hi;
  logic signed [65:0] p_sh28, negp2, b1x_full;
  logic signed [43:0] psh44;
  logic signed [43:0] y_sum, s1_sum, s2_sum;
  logic signed [32:0] dlt;
  logic [31:0] dens;
  logic [27:0] rel_r;
  logic [14:0] rel_m7;
  logic [28:0] rel_n;
  logic [27:0] t_raw;
  logic [46:0] rem2;
  logic div_ge;
  logic [32:0] a_sum;
  logic thr_hit;
  logic [31:0] target;

  assign absx   = x_q[23] ? (~x_q + 24'd1) : x_q;
  assign rect   = {absx, 8'd0};
  assign rise_f = rect > fast_q;
  assign rise_s = rect > slow_q;

  assign p_hi     = prod_q[63:32];
  assign p_sh28   = prod_q >>> 28;
  assign psh44    = p_sh28[43:0];
  assign negp2    = -(prod_q <<< 1);
  assign b1x_full = negp2 >>> 28;

  assign y_sum  = psh44 + 44'(s1_q);
  assign s1_sum = 44'(b1x_q) - psh44 + 44'(s2_q);
  assign s2_sum = 44'(b0x_q) - psh44;

  assign dlt = $signed({1'b0, fast_q}) - $signed({1'b0, slow_q});
  always_comb begin
    if (dlt[32] || (dlt == '0)) begin
      dens = '0;
    end else if (dlt > 33'sd268435456) begin
      dens = ngh_pkg::ONE_Q31;
    end else begin
      dens = {dlt[28:0], 3'd0};
    end
  end

  assign rel_r  = {release_q, 16'd0};
  assign rel_m7 = ({3'd0, release_q} << 3) - {3'd0, release_q};
  assign rel_n  = {rel_m7, 14'd0};
  assign t_raw  = rel_r - prod_q[58:31];

  assign rem2   = {rem_q, 1'b0};
  assign div_ge = rem2 >= {1'b0, den_q};

  assign a_sum = {1'b0, quo_q} - {2'd0, x2_q[31:1]} + {3'd0, prod_q[63:34]};

  assign thr_hit = fast_q > {1'b0, threshold_q, 8'd0};
  assign target  = thr_hit ? ngh_pkg::ONE_Q31 : 32'd0;

  assign sts_o.gate_en = gate_en_q;
  assign sts_o.opening = thr_hit && (gain_q < ngh_pkg::ONE_Q31);

  always_comb begin
    ma     = '0;
    mb     = '0;
    mul_en = 1'b1;
    case (cmd_i.op)
      ngh_pkg::OP_ENV_FAST: begin
        ma = $signed({1'b0, rise_f ? ALPHA_5 : ALPHA_60});
        mb = $signed({1'b0, rise_f ? (rect - fast_q) : (fast_q - rect)});
      end
      ngh_pkg::OP_ENV_SLOW: begin
        ma = $signed({1'b0, ALPHA_250});
        mb = $signed({1'b0, slow_q - rect});
      end
      ngh_pkg::OP_FILT_B0: begin
        ma = 33'(b0_q);
        mb = 33'(x_q);
      end
      ngh_pkg::OP_FILT_A1: begin
        ma = 33'(a1_q);
        mb = 33'(y_q);
      end
      ngh_pkg::OP_FILT_A2: begin
        ma = 33'(a2_q);
        mb = 33'(y_q);
      end
      ngh_pkg::OP_GATE_R35: begin
        ma = $signed({4'd0, rel_n});
        mb = $signed({1'b0, ngh_pkg::RECIP_FIVE});
      end
      ngh_pkg::OP_GATE_T: begin
        ma = $signed({5'd0, rd_q});
        mb = $signed({1'b0, dens_q});
      end
      ngh_pkg::OP_GATE_DEN: begin
        ma = $signed({5'd0, t_q});
        mb = $signed(33'(SAMPLE_RATE));
      end
      ngh_pkg::OP_OPEN: begin
        ma = $signed({1'b0, ngh_pkg::OPEN_STEP_Q32});
        mb = $signed({1'b0, ngh_pkg::ONE_Q31 - gain_q});
      end
      ngh_pkg::OP_SQR: begin
        ma = $signed({1'b0, quo_q});
        mb = $signed({1'b0, quo_q});
      end
      ngh_pkg::OP_CUBE: begin
        ma = $signed({1'b0, x2_q});
        mb = $signed({1'b0, quo_q});
      end
      ngh_pkg::OP_SIXTH: begin
        ma = $signed({1'b0, x3_q});
        mb = $signed({1'b0, ngh_pkg::RECIP_THREE});
      end
      ngh_pkg::OP_FOLLOW: begin
        ma = $signed({1'b0, a_q});
        mb = $signed({1'b0, gain_q - target});
      end
      ngh_pkg::OP_OUT: begin
        ma = 33'(y_q);
        mb = $signed({1'b0, gain_q});
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= ma * mb;
    end
    if (cmd_i.load) begin
      x_q <= sample_in_i;
    end
    case (cmd_i.op)
      ngh_pkg::OP_FILT_Y: begin
        b0x_q <= p_sh28[39:0];
        b1x_q <= b1x_full[39:0];
        y_q   <= sat32(y_sum);
      end
      ngh_pkg::OP_GATE_R35: begin
        dens_q <= dens;
      end
      ngh_pkg::OP_GATE_RD: begin
        rd_q <= rel_r - prod_q[61:34];
      end
      ngh_pkg::OP_GATE_TS: begin
        t_q <= (t_raw < MIN_RELEASE) ? MIN_RELEASE : t_raw;
      end
      ngh_pkg::OP_DIV_INIT: begin
        den_q <= prod_q[45:0];
        rem_q <= DIV_REM_INIT;
        quo_q <= '0;
      end
      ngh_pkg::OP_DIV: begin
        rem_q <= div_ge ? 46'(rem2 - {1'b0, den_q}) : rem2[45:0];
        quo_q <= {quo_q[30:0], div_ge};
      end
      ngh_pkg::OP_X2: begin
        x2_q <= p_hi;
      end
      ngh_pkg::OP_X3: begin
        x3_q <= p_hi;
      end
      ngh_pkg::OP_ALPHA: begin
        a_q <= a_sum[32] ? 32'hFFFF_FFFF : a_sum[31:0];
      end
      default: begin
      end
    endcase
    if (cmd_i.out_load) begin
      sample_out_q <= sat24(prod_q >>> 31);
      gain_out_q   <= gain_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_en_q   <= 1'b0;
      threshold_q <= 23'd26529;
      release_q   <= 12'd100;
      b0_q        <= 32'sd265962360;
      a1_q        <= -32'sd531902172;
      a2_q        <= 32'sd263511813;
      fast_q      <= '0;
      slow_q      <= '0;
      gain_q      <= ngh_pkg::ONE_Q31;
      s1_q        <= '0;
      s2_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ngh_pkg::CFG_GATE_ENABLE: gate_en_q   <= cfg_data_i[0];
          ngh_pkg::CFG_THRESHOLD:   threshold_q <= cfg_data_i[22:0];
          ngh_pkg::CFG_RELEASE_MS:  release_q   <= cfg_data_i[11:0];
          ngh_pkg::CFG_HPF_B0:      b0_q        <= cfg_data_i;
          ngh_pkg::CFG_HPF_A1:      a1_q        <= cfg_data_i;
          ngh_pkg::CFG_HPF_A2:      a2_q        <= cfg_data_i;
          default: begin
          end
        endcase
      end
      case (cmd_i.op)
        ngh_pkg::OP_ENV_SLOW: begin
          fast_q <= rise_f ? (fast_q + p_hi) : (fast_q - p_hi);
        end
        ngh_pkg::OP_FILT_B0: begin
          slow_q <= rise_s ? fast_q : (slow_q - p_hi);
        end
        ngh_pkg::OP_FILT_A2: begin
          s1_q <= sat40(s1_sum);
        end
        ngh_pkg::OP_FILT_END: begin
          s2_q <= sat40(s2_sum);
        end
        ngh_pkg::OP_FOLLOW_END: begin
          gain_q <= gain_q - p_hi;
        end
        ngh_pkg::OP_OPEN_END: begin
          gain_q <= gain_q + p_hi;
        end
        ngh_pkg::OP_UNITY: begin
          gain_q <= ngh_pkg::ONE_Q31;
        end
        default: begin
        end
      endcase
    end
  end

  assign sample_out_o = sample_out_q;
  assign gain_now_o   = gain_out_q;

endmodule

`default_nettype wire

// ----- design/noise_gate_with_highpass.sv -----
// A request takes one of three paths: gate off, gate opening, or gate releasing. The release
// path is the longest, as it runs the 32-step restoring divider that forms the release
// coefficient; all products share one 33 x 33 bit multiplier. A new request is taken only
// once the previous one has reached the result register.
// The result register lets a new request in while the previous result waits.
// Asynchronous active-low reset clears the envelopes and filter state, sets the gain to one
// and loads the register defaults.
`default_nettype none

module noise_gate_with_highpass #(
  parameter int unsigned SAMPLE_RATE = 48000
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic signed [23:0]              sample_in_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic signed [23:0]                   sample_out_o,
  output logic [31:0]                          gain_now_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [ngh_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [ngh_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  ngh_pkg::cmd_t cmd;
  ngh_pkg::sts_t sts;

  ngh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ngh_dp #(
    .SAMPLE_RATE (SAMPLE_RATE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .sample_in_i  (sample_in_i),
    .sample_out_o (sample_out_o),
    .gain_now_o   (gain_now_o)
  );

endmodule

`default_nettype wire

// ----- design/ngh_chk.sv -----
`default_nettype none

module ngh_chk (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_valid_i,
  input wire logic                            in_ready_o,
  input wire logic signed [23:0]              sample_in_i,
  input wire logic                            out_valid_o,
  input wire logic                            out_ready_i,
  input wire logic signed [23:0]              sample_out_o,
  input wire logic [31:0]                     gain_now_o,
  input wire logic                            cfg_we_i,
  input wire logic [ngh_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input wire logic [ngh_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  // A result that is not taken holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_out_o)
      && $stable(gain_now_o))
    else $error("result changed while stalled");

  // The gate gain never exceeds one.
  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> gain_now_o <= ngh_pkg::ONE_Q31)
    else $error("gain above one");

  // A request is worked on through a sequence of states, so the block is busy right after it.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken on back-to-back cycles");

endmodule

bind noise_gate_with_highpass ngh_chk u_ngh_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .sample_in_i  (sample_in_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .sample_out_o (sample_out_o),
  .gain_now_o   (gain_now_o),
  .cfg_we_i     (cfg_we_i),
  .cfg_idx_i    (cfg_idx_i),
  .cfg_data_i   (cfg_data_i)
);

`default_nettype wire
